>>> hw/rtl/nnis_pkg.sv
// Shared constants, field widths and stage-control types for the
// nearest-neighbour image scaler. No dependencies.
package nnis_pkg;

  localparam int MAX_SIDE = 320;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int SIDE_W   = 9;
  localparam int COLOR_W  = 16;
  localparam int DEST_W   = 15;
  localparam int ZOOM_W   = 14;
  localparam int INV_W    = 9;
  localparam int DIFF_W   = DEST_W + 1;
  localparam int PROD_W   = DIFF_W + INV_W + 1;
  localparam int F_W      = PROD_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ZOOM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_C  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_R  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 14'd256;
  localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 14'd8192;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET = 14'd256;
  localparam logic [INV_W-1:0]  INV_RESET  = 9'd256;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd320;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

  // 65536 as the divider's starting remainder
  localparam int REM_W = 17;
  localparam logic [REM_W-1:0] DIVIDEND = 17'h10000;
  // divisor shifted up by the top quotient bit position
  localparam int DIVR_W = ZOOM_W + INV_W - 1;

  // advance strobes for the arithmetic stages of one axis
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } nnis_adv_t;

endpackage

>>> hw/rtl/nearest_neighbor_image_scaler_core.sv
// Nearest-neighbour scaler core: five-stage pipeline, one transaction per cycle
// while the output is not stalled and the inverse divider is idle. A request
// transaction shows its result at the output stage. After a zoom write the
// inverse divider runs, during which in_tready is low.
// Reset (synchronous, rst_n low): pipeline empty, inverse step 256 (zoom 256),
// pivots 0, sizes 320; the pixel store is not cleared.
module nearest_neighbor_image_scaler_core
  import nnis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [8:0] load_col, [17:9] load_row, [33:18] load_color,
  // [48:34] dest_col, [63:49] dest_row
  input  logic [63:0]           in_tdata,
  // [0] opcode
  input  logic                  in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] color_out
  output logic [15:0]           out_tdata,
  // [0] covered
  output logic                  out_tuser,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Input field unpack
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0]        in_load_col;
  logic [SIDE_W-1:0]        in_load_row;
  logic [COLOR_W-1:0]       in_load_color;
  logic signed [DEST_W-1:0] in_dest_col;
  logic signed [DEST_W-1:0] in_dest_row;

  assign in_load_col   = in_tdata[8:0];
  assign in_load_row   = in_tdata[17:9];
  assign in_load_color = in_tdata[33:18];
  assign in_dest_col   = $signed(in_tdata[48:34]);
  assign in_dest_row   = $signed(in_tdata[63:49]);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] pivot_col_r;
  logic [SIDE_W-1:0] pivot_row_r;
  logic [SIDE_W-1:0] width_r;
  logic [SIDE_W-1:0] height_r;
  logic              zoom_wr;

  // zoom itself is only needed by the divider, which samples it on the write
  assign zoom_wr = cfg_we && (cfg_index == REG_ZOOM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_col_r <= '0;
      pivot_row_r <= '0;
      width_r     <= SIDE_RESET;
      height_r    <= SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIVOT_C: pivot_col_r <= cfg_wdata[SIDE_W-1:0];
        REG_PIVOT_R: pivot_row_r <= cfg_wdata[SIDE_W-1:0];
        REG_WIDTH:   width_r     <= cfg_wdata[SIDE_W-1:0];
        REG_HEIGHT:  height_r    <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes beyond the store are treated as the store side
  logic [SIDE_W-1:0] width_c;
  logic [SIDE_W-1:0] height_c;

  assign width_c  = (width_r  > SIDE_MAX) ? SIDE_MAX : width_r;
  assign height_c = (height_r > SIDE_MAX) ? SIDE_MAX : height_r;

  // ---------------------------------------------------------------------------
  // Inverse step: floor(65536 / zoom), iterative
  // ---------------------------------------------------------------------------
  logic             div_busy;
  logic [INV_W-1:0] inv_step;

  nnis_inv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (zoom_wr),
    .zoom  (cfg_wdata[ZOOM_W-1:0]),
    .busy  (div_busy),
    .inv   (inv_step)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage takes new contents when it is empty or its
  // successor moves, so bubbles collapse and a stall only backs up as far
  // as needed. Loads leave after stage 4 (store write); requests go on to
  // the output stage.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  nnis_adv_t adv;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_tready = rdy1 && !div_busy;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  // op and load payload travel alongside the axis stages
  logic               op1_r, op2_r, op3_r, op4_r;
  logic               lok1_r, lok2_r, lok3_r, lok4_r;
  logic [ADDR_W-1:0]  la1_r, la2_r, la3_r, la4_r;
  logic [COLOR_W-1:0] lc1_r, lc2_r, lc3_r, lc4_r;

  logic              in_lok;
  logic [ADDR_W-1:0] in_laddr;

  assign in_lok   = (in_load_col < SIDE_MAX) && (in_load_row < SIDE_MAX);
  assign in_laddr = ADDR_W'(in_load_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(in_load_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid && in_tready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r && (op4_r == OP_REQ);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r  <= in_tuser;
      lok1_r <= in_lok;
      la1_r  <= in_laddr;
      lc1_r  <= in_load_color;
    end
    if (rdy2) begin
      op2_r  <= op1_r;
      lok2_r <= lok1_r;
      la2_r  <= la1_r;
      lc2_r  <= lc1_r;
    end
    if (rdy3) begin
      op3_r  <= op2_r;
      lok3_r <= lok2_r;
      la3_r  <= la2_r;
      lc3_r  <= lc2_r;
    end
    if (rdy4) begin
      op4_r  <= op3_r;
      lok4_r <= lok3_r;
      la4_r  <= la3_r;
      lc4_r  <= lc3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis mapping, stages 1..4
  // ---------------------------------------------------------------------------
  logic              in_x, in_y;
  logic [SIDE_W-1:0] sx, sy;

  nnis_axis u_axis_x (
    .clk    (clk),
    .adv    (adv),
    .d      (in_dest_col),
    .pivot  (pivot_col_r),
    .size   (width_c),
    .inv    (inv_step),
    .hit    (in_x),
    .idx    (sx)
  );

  nnis_axis u_axis_y (
    .clk    (clk),
    .adv    (adv),
    .d      (in_dest_row),
    .pivot  (pivot_row_r),
    .size   (height_c),
    .inv    (inv_step),
    .hit    (in_y),
    .idx    (sy)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: pixel store. Loads write and requests read at the same stage,
  // so a request always sees every load accepted before it.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] store_mem [DEPTH];
  logic [ADDR_W-1:0]  raddr;
  logic [COLOR_W-1:0] rd_r;
  logic               cov_r;
  logic               cov4;

  assign cov4  = in_x && in_y;
  assign raddr = ADDR_W'(sy) * ADDR_W'(MAX_SIDE) + ADDR_W'(sx);

  always_ff @(posedge clk) begin
    if (v4_r && rdy5 && (op4_r == OP_LOAD) && lok4_r) begin
      store_mem[la4_r] <= lc4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      rd_r  <= store_mem[raddr];
      cov_r <= cov4;
    end
  end

  // ---------------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------------
  assign out_tvalid = v5_r;
  assign out_tuser  = cov_r;
  assign out_tdata  = cov_r ? rd_r : '0;

endmodule

>>> hw/rtl/nnis_inv_div.sv
// Restoring divider deriving the inverse step floor(65536 / zoom).
// Depends on nnis_pkg. One quotient bit per cycle, MSB first.
module nnis_inv_div
  import nnis_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ZOOM_W-1:0] zoom,
  output logic              busy,
  output logic [INV_W-1:0]  inv
);

  logic              busy_r;
  logic [INV_W-1:0]  inv_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIVR_W-1:0] divr_r;
  logic [INV_W-1:0]  q_r;
  logic [3:0]        cnt_r;

  logic [ZOOM_W-1:0] zsat;
  logic              ge;
  logic [INV_W-1:0]  q_nxt;

  always_comb begin
    if (zoom < ZOOM_MIN) begin
      zsat = ZOOM_MIN;
    end else if (zoom > ZOOM_MAX) begin
      zsat = ZOOM_MAX;
    end else begin
      zsat = zoom;
    end
  end

  assign ge    = DIVR_W'(rem_r) >= divr_r;
  assign q_nxt = {q_r[INV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      inv_r  <= INV_RESET;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == 4'd0) begin
      busy_r <= 1'b0;
      inv_r  <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DIVIDEND;
      divr_r <= {zsat, {(INV_W-1){1'b0}}};
      q_r    <= '0;
      cnt_r  <= 4'(INV_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - divr_r[REM_W-1:0];
      end
      divr_r <= divr_r >> 1;
      q_r    <= q_nxt;
      cnt_r  <= cnt_r - 4'd1;
    end
  end

  assign busy = busy_r;
  assign inv  = inv_r;

endmodule

>>> hw/rtl/nnis_axis.sv
// Four-stage coordinate mapper for one axis:
// (d - pivot) * inv + pivot*256 + 128, then range check. Depends on nnis_pkg.
module nnis_axis
  import nnis_pkg::*;
(
  input  logic                     clk,
  input  nnis_adv_t                adv,
  input  logic signed [DEST_W-1:0] d,
  input  logic [SIDE_W-1:0]        pivot,
  input  logic [SIDE_W-1:0]        size,
  input  logic [INV_W-1:0]         inv,
  output logic                     hit,
  output logic [SIDE_W-1:0]        idx
);

  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [F_W-1:0]    f_r;
  logic                     hit_r;
  logic [SIDE_W-1:0]        idx_r;

  logic [F_W-1:0]           base;
  logic [F_W-10:0]          fint;

  assign base = F_W'({pivot, 8'h80});
  assign fint = f_r[F_W-2:8];

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      diff_r <= DIFF_W'(d) - DIFF_W'($signed({1'b0, pivot}));
    end
    if (adv.s2) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'($signed({1'b0, inv}));
    end
    if (adv.s3) begin
      f_r <= F_W'(prod_r) + $signed(base);
    end
    if (adv.s4) begin
      // non-negative and below size*256
      hit_r <= !f_r[F_W-1] && (fint < (F_W-9)'(size));
      idx_r <= f_r[SIDE_W+7:8];
    end
  end

  assign hit = hit_r;
  assign idx = idx_r;

endmodule

>>> hw/rtl/nnis_checker.sv
// Port-level checks on the scaler core, attached by bind.
// Depends on nnis_pkg and nearest_neighbor_image_scaler_core.
module nnis_checker
  import nnis_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [15:0]          out_tdata,
  input logic                 out_tuser,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // uncovered results carry no colour
  a_uncov_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 16'h0000))
    else $error("uncovered result with non-zero colour");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a zoom write starts the inverse divider, which holds off input
  a_zoom_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == REG_ZOOM)) |=> !in_tready)
    else $error("input accepted while inverse step is recomputed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index)
);
